// File: rtl/ksm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ksm_pkg;

  localparam int MAX_INTERVALS = 1024;
  localparam int COORD_WIDTH   = 31;
  localparam int ID_WIDTH      = 32;
  localparam int ADDR_W        = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]    read_id;
    logic [COORD_WIDTH-1:0] span_begin;
    logic [COORD_WIDTH-1:0] span_end;
  } entry_t;

  // results of the shared compare unit
  typedef struct packed {
    logic key_gt;        // a sorts after b in read id, then begin, then end order
    logic id_eq;         // same read id
    logic begin_le_end;  // b begin at or before a end
    logic end_gt_end;    // b end beyond a end
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_NEXT,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_MERGE_INIT,
    ST_MERGE_FIRST,
    ST_MERGE_STEP,
    ST_MERGE_FLUSH,
    ST_FETCH_WAIT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ksm_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module ksm_cmp (
  input  ksm_pkg::entry_t   a,
  input  ksm_pkg::entry_t   b,
  output ksm_pkg::cmp_res_t res
);
  import ksm_pkg::*;

  // lexicographic order is one wide unsigned compare of the packed keys
  assign res.key_gt       = a > b;
  assign res.id_eq        = a.read_id == b.read_id;
  assign res.begin_le_end = b.span_begin <= a.span_end;
  assign res.end_gt_end   = b.span_end > a.span_end;

endmodule

`default_nettype wire

// File: rtl/keyed_interval_sort_merge_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   valid      stall      payload
// input     in_valid   in_stall   func, read_id, span_begin, span_end, last_load
// result    res_valid  res_stall  out_valid, out_read_id, out_begin, out_end,
//                                 out_last, overflowed
//
// a load is taken from idle; a fetch then waits until the result register is free.
// the final load starts an insertion sort over the store and a merge sweep, all
// through one shared compare unit; in_stall is high meanwhile.
// synchronous reset clears control state only; the store is not cleared.
// a stalled result holds in its register while further loads are taken.

module keyed_interval_sort_merge_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          func,
  input  wire [ksm_pkg::ID_WIDTH-1:0]  read_id,
  input  wire [ksm_pkg::COORD_WIDTH-1:0] span_begin,
  input  wire [ksm_pkg::COORD_WIDTH-1:0] span_end,
  input  wire                          last_load,
  output logic                         res_valid,
  input  wire                          res_stall,
  output logic                         out_valid,
  output logic [ksm_pkg::ID_WIDTH-1:0] out_read_id,
  output logic [ksm_pkg::COORD_WIDTH-1:0] out_begin,
  output logic [ksm_pkg::COORD_WIDTH-1:0] out_end,
  output logic                         out_last,
  output logic                         overflowed
);
  import ksm_pkg::*;

  state_t state, state_next;
  entry_t mem [MAX_INTERVALS];
  entry_t rd_q, key, key_next, kept, kept_next, cmp_a, cmp_b, wr_data, in_entry;
  addr_t  rd_addr, wr_addr;
  logic   wr_en;
  cmp_res_t cmp;

  cnt_t loaded, loaded_next, merged, merged_next, ptr, ptr_next;
  cnt_t i_cnt, i_next, j_cnt, j_next, k_cnt, k_next, base_cnt;
  logic ovf, ovf_next, fetching, fetching_next, hit, hit_next;
  logic accept, out_free, res_valid_next, out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;
  assign out_free = !res_valid || !res_stall;
  assign in_entry = '{read_id: read_id, span_begin: span_begin, span_end: span_end};
  assign base_cnt = fetching ? '0 : loaded;

  ksm_cmp u_cmp (.a(cmp_a), .b(cmp_b), .res(cmp));

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_FETCH) state_next = ST_FETCH_WAIT;
          else if (last_load) state_next = ST_SORT_NEXT;
        end
      end
      ST_SORT_NEXT:   state_next = (i_cnt >= loaded) ? ST_MERGE_INIT : ST_SORT_KEY;
      ST_SORT_KEY:    state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!cmp.key_gt || j_cnt == cnt_t'(1)) state_next = ST_SORT_PLACE;
      end
      ST_SORT_PLACE:  state_next = ST_SORT_NEXT;
      ST_MERGE_INIT:  state_next = (loaded == '0) ? ST_IDLE : ST_MERGE_FIRST;
      ST_MERGE_FIRST: state_next = ST_MERGE_STEP;
      ST_MERGE_STEP:  state_next = (i_cnt >= loaded) ? ST_MERGE_FLUSH : ST_MERGE_STEP;
      ST_MERGE_FLUSH: state_next = ST_IDLE;
      ST_FETCH_WAIT:  state_next = out_free ? ST_IDLE : ST_FETCH_WAIT;
      default:        state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    loaded_next    = loaded;
    merged_next    = merged;
    ptr_next       = ptr;
    ovf_next       = ovf;
    fetching_next  = fetching;
    hit_next       = hit;
    i_next         = i_cnt;
    j_next         = j_cnt;
    k_next         = k_cnt;
    key_next       = key;
    kept_next      = kept;
    wr_en          = 1'b0;
    wr_addr        = base_cnt[ADDR_W-1:0];
    wr_data        = in_entry;
    rd_addr        = ptr[ADDR_W-1:0];
    cmp_a          = kept;
    cmp_b          = rd_q;
    out_load       = 1'b0;
    res_valid_next = res_valid && res_stall;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_LOAD) begin
          if (fetching) begin
            merged_next   = '0;
            ptr_next      = '0;
            ovf_next      = 1'b0;
            fetching_next = 1'b0;
          end
          if (base_cnt < cnt_t'(MAX_INTERVALS)) begin
            wr_en       = 1'b1;
            loaded_next = base_cnt + cnt_t'(1);
          end else begin
            loaded_next = base_cnt;
            ovf_next    = 1'b1;
          end
          i_next = cnt_t'(1);
        end else if (accept) begin
          hit_next = fetching && (ptr < merged);
        end
      end
      ST_SORT_NEXT: begin
        rd_addr = i_cnt[ADDR_W-1:0];
        j_next  = i_cnt;
      end
      ST_SORT_KEY: begin
        key_next = rd_q;
        rd_addr  = addr_t'(j_cnt - cnt_t'(1));
      end
      ST_SORT_CMP: begin
        cmp_a = rd_q;
        cmp_b = key;
        rd_addr = addr_t'(j_cnt - cnt_t'(2));
        if (cmp.key_gt) begin
          wr_en   = 1'b1;
          wr_addr = j_cnt[ADDR_W-1:0];
          wr_data = rd_q;
          j_next  = j_cnt - cnt_t'(1);
        end
      end
      ST_SORT_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = j_cnt[ADDR_W-1:0];
        wr_data = key;
        i_next  = i_cnt + cnt_t'(1);
      end
      ST_MERGE_INIT: begin
        rd_addr = '0;
        if (loaded == '0) begin
          merged_next   = '0;
          ptr_next      = '0;
          fetching_next = 1'b1;
        end
      end
      ST_MERGE_FIRST: begin
        kept_next = rd_q;
        k_next    = '0;
        i_next    = cnt_t'(1);
        rd_addr   = addr_t'(1);
      end
      ST_MERGE_STEP: begin
        rd_addr = addr_t'(i_cnt + cnt_t'(1));
        if (i_cnt < loaded) begin
          i_next = i_cnt + cnt_t'(1);
          if (cmp.id_eq && cmp.begin_le_end) begin
            if (cmp.end_gt_end) kept_next.span_end = rd_q.span_end;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = k_cnt[ADDR_W-1:0];
            wr_data   = kept;
            k_next    = k_cnt + cnt_t'(1);
            kept_next = rd_q;
          end
        end
      end
      ST_MERGE_FLUSH: begin
        wr_en         = 1'b1;
        wr_addr       = k_cnt[ADDR_W-1:0];
        wr_data       = kept;
        merged_next   = k_cnt + cnt_t'(1);
        ptr_next      = '0;
        fetching_next = 1'b1;
      end
      ST_FETCH_WAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          res_valid_next = 1'b1;
          if (hit) ptr_next = ptr + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      loaded    <= '0;
      merged    <= '0;
      ptr       <= '0;
      ovf       <= 1'b0;
      fetching  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      loaded    <= loaded_next;
      merged    <= merged_next;
      ptr       <= ptr_next;
      ovf       <= ovf_next;
      fetching  <= fetching_next;
      res_valid <= res_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_cnt <= i_next;
    j_cnt <= j_next;
    k_cnt <= k_next;
    key   <= key_next;
    kept  <= kept_next;
    hit   <= hit_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_valid   <= hit;
      out_read_id <= hit ? rd_q.read_id : '0;
      out_begin   <= hit ? rd_q.span_begin : '0;
      out_end     <= hit ? rd_q.span_end : '0;
      out_last    <= hit && (ptr + cnt_t'(1) == merged);
      overflowed  <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ksm_pkg::*;

  // one input transaction plus sender controls
  typedef struct {
    logic                   func;
    logic [ID_WIDTH-1:0]    id;
    logic [COORD_WIDTH-1:0] b;
    logic [COORD_WIDTH-1:0] e;
    logic                   last;
    bit                     drain;  // wait until every result is back
    bit                     hold;   // start a long receiver hold-off
  } stim_t;

  typedef struct packed {
    logic                   vld;
    logic [ID_WIDTH-1:0]    id;
    logic [COORD_WIDTH-1:0] b;
    logic [COORD_WIDTH-1:0] e;
    logic                   last;
    logic                   ovf;
  } interval_res_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_LOAD;
  logic [ID_WIDTH-1:0] read_id = '0;
  logic [COORD_WIDTH-1:0] span_begin = '0;
  logic [COORD_WIDTH-1:0] span_end = '0;
  logic last_load = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic out_valid;
  logic [ID_WIDTH-1:0] out_read_id;
  logic [COORD_WIDTH-1:0] out_begin;
  logic [COORD_WIDTH-1:0] out_end;
  logic out_last;
  logic overflowed;

  keyed_interval_sort_merge_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .read_id(read_id), .span_begin(span_begin),
    .span_end(span_end), .last_load(last_load),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_valid(out_valid), .out_read_id(out_read_id), .out_begin(out_begin),
    .out_end(out_end), .out_last(out_last), .overflowed(overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t         pending_items[$];
  interval_res_t merged_expect[$];

  // shadow copy of the interval store and its control
  entry_t shadow[MAX_INTERVALS];
  int     shadow_loaded = 0;
  int     shadow_merged = 0;
  int     shadow_fetch = 0;
  bit     shadow_ovf = 0;
  bit     shadow_fetching = 0;

  int n_loads = 0, n_fetches = 0, n_results = 0, n_valid_results = 0;
  int n_accepted = 0, mismatches = 0, idle_cycles = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  function automatic bit key_after(entry_t p, entry_t q);
    if (p.read_id != q.read_id) return p.read_id > q.read_id;
    if (p.span_begin != q.span_begin) return p.span_begin > q.span_begin;
    return p.span_end > q.span_end;
  endfunction

  // insertion sort then one merge sweep over the shadow store
  task automatic sort_and_merge_shadow();
    entry_t t;
    int j, kept;
    for (int i = 1; i < shadow_loaded; i++) begin
      j = i;
      while (j > 0 && key_after(shadow[j-1], shadow[j])) begin
        t = shadow[j-1]; shadow[j-1] = shadow[j]; shadow[j] = t;
        j--;
      end
    end
    if (shadow_loaded == 0) begin
      shadow_merged = 0;
      return;
    end
    kept = 0;
    for (int i = 1; i < shadow_loaded; i++) begin
      if (shadow[i].read_id == shadow[kept].read_id &&
          shadow[i].span_begin <= shadow[kept].span_end) begin
        if (shadow[i].span_end > shadow[kept].span_end)
          shadow[kept].span_end = shadow[i].span_end;
      end else begin
        kept++;
        shadow[kept] = shadow[i];
      end
    end
    shadow_merged = kept + 1;
  endtask

  task automatic predict_interval(stim_t s);
    interval_res_t r;
    if (s.func == FUNC_LOAD) begin
      n_loads++;
      if (shadow_fetching) begin
        shadow_loaded = 0; shadow_merged = 0; shadow_fetch = 0;
        shadow_ovf = 0; shadow_fetching = 0;
      end
      if (shadow_loaded < MAX_INTERVALS) begin
        shadow[shadow_loaded] = '{read_id: s.id, span_begin: s.b, span_end: s.e};
        shadow_loaded++;
      end else begin
        shadow_ovf = 1;
      end
      if (s.last) begin
        sort_and_merge_shadow();
        shadow_fetch = 0;
        shadow_fetching = 1;
      end
    end else begin
      n_fetches++;
      r = '0;
      r.ovf = shadow_ovf;
      if (shadow_fetching && shadow_fetch < shadow_merged) begin
        r.vld  = 1'b1;
        r.id   = shadow[shadow_fetch].read_id;
        r.b    = shadow[shadow_fetch].span_begin;
        r.e    = shadow[shadow_fetch].span_end;
        r.last = (shadow_fetch + 1 == shadow_merged);
        shadow_fetch++;
      end
      merged_expect.push_back(r);
    end
  endtask

  // idling profile follows progress through the stimulus
  function automatic bit sender_idles();
    case ((n_accepted / 100) % 4)
      1: return $urandom_range(99) < 46;
      3: return $urandom_range(99) < 35;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case ((n_accepted / 100) % 4)
      2: return $urandom_range(99) < 46;
      3: return $urandom_range(99) < 35;
      default: return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    stim_t cur;
    bit took;
    bit hold_now;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold_now = 1'b0;
      took = in_valid && !in_stall;
      if (took) begin
        cur.func = func; cur.id = read_id; cur.b = span_begin;
        cur.e = span_end; cur.last = last_load;
        predict_interval(cur);
        n_accepted++;
      end
      if (took || !in_valid) begin
        if (pending_items.size() > 0 &&
            !(pending_items[0].drain && merged_expect.size() > 0) && !sender_idles()) begin
          cur = pending_items.pop_front();
          func <= cur.func; read_id <= cur.id; span_begin <= cur.b;
          span_end <= cur.e; last_load <= cur.last;
          in_valid <= 1'b1;
          hold_now = cur.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
      hold_req <= hold_now;
    end
  end

  // monitor and result check
  always @(posedge clk) begin
    interval_res_t got, want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got = '{out_valid, out_read_id, out_begin, out_end, out_last, overflowed};
        n_results++;
        if (out_valid) n_valid_results++;
        if (merged_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = merged_expect.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      res_stall <= (hold_cnt > 0) ? 1'b1 : receiver_stalls();
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: no transaction for %0d cycles", idle_cycles);
        $display("[keyed_interval_sort_merge_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_load(logic [ID_WIDTH-1:0] id, logic [COORD_WIDTH-1:0] b,
                           logic [COORD_WIDTH-1:0] e, logic last);
    stim_t s;
    s = '{func: FUNC_LOAD, id: id, b: b, e: e, last: last, drain: 0, hold: 0};
    pending_items.push_back(s);
  endtask

  task automatic push_fetch(bit drain, bit hold);
    stim_t s;
    s = '{func: FUNC_FETCH, id: $urandom, b: COORD_WIDTH'($urandom),
          e: COORD_WIDTH'($urandom), last: 1'($urandom_range(1)),
          drain: drain, hold: hold};
    pending_items.push_back(s);
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(9))
      0: return COORD_WIDTH'($urandom);
      1: return '1;
      2: return '0;
      default: return COORD_WIDTH'($urandom_range(60));
    endcase
  endfunction

  // stimulus
  initial begin
    int k, extra, total;
    logic [ID_WIDTH-1:0] base;
    // directed: fetch while loading, extremes, touching, contained,
    // duplicate, begin above end, zero interval, ignored last flag
    push_fetch(0, 0);
    push_load(32'd5, 31'd20, 31'd30, 1'b0);
    push_load('1, '1, '1, 1'b0);
    push_load(32'd5, 31'd10, 31'd20, 1'b0);
    push_load(32'd0, 31'd0, 31'd0, 1'b0);
    push_load(32'd5, 31'd12, 31'd15, 1'b0);
    push_load(32'd5, 31'd10, 31'd20, 1'b0);
    push_load(32'd5, 31'd40, 31'd35, 1'b0);
    push_load(32'd6, 31'd0, 31'd1, 1'b0);
    push_fetch(0, 0);
    push_load(32'd5, 31'd36, 31'd38, 1'b1);
    for (int i = 0; i < 8; i++) push_fetch(0, 0);
    // load while fetching starts a new set
    push_load(32'd1, 31'd3, 31'd4, 1'b0);
    push_load(32'd1, 31'd1, 31'd2, 1'b1);
    push_fetch(0, 0);
    push_load(32'd9, 31'd0, 31'd7, 1'b1);
    push_fetch(0, 0);
    push_fetch(0, 0);

    // full store: presorted so the sort stays linear, then dropped loads
    for (int i = 0; i < MAX_INTERVALS + 2; i++)
      push_load(i, 31'd0, 31'd1, i == MAX_INTERVALS + 1);
    push_fetch(1, 1);
    for (int i = 0; i < 4; i++) push_fetch(0, 0);

    // random sets, mostly well formed
    total = 0;
    while (total < 400) begin
      k = $urandom_range(1, 12);
      base = ($urandom_range(4) == 0) ? $urandom : $urandom_range(3);
      for (int i = 0; i < k; i++) begin
        push_load(($urandom_range(7) == 0) ? $urandom : base + $urandom_range(2),
                  rand_coord(), rand_coord(), i == k - 1);
        if ($urandom_range(19) == 0) push_fetch(0, 0);
      end
      extra = $urandom_range(2);
      if ($urandom_range(9) == 0) extra = -$urandom_range(1, k);
      for (int i = 0; i < k + extra; i++) push_fetch(i == 0 && $urandom_range(7) == 0, 0);
      total += 2 * k + extra;
    end
    // one larger unsorted set
    for (int i = 0; i < 40; i++)
      push_load($urandom_range(3), rand_coord(), rand_coord(), i == 39);
    for (int i = 0; i < 42; i++) push_fetch(0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() > 0 || in_valid || merged_expect.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (merged_expect.size() > 0) mismatches++;
    $display("covered %0d loads and %0d fetches, %0d results (%0d merged intervals)",
             n_loads, n_fetches, n_results, n_valid_results);
    $display("including a full store with dropped loads and a long result hold-off");
    if (mismatches == 0) begin
      $display("[keyed_interval_sort_merge_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[keyed_interval_sort_merge_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ksm_pkg.sv
rtl/ksm_cmp.sv
rtl/keyed_interval_sort_merge_unit.sv
dv/tb_top.sv
